>>> rtl/core/sws_pkg.sv
// Shared types, constants and arithmetic helpers of the SH-wave grid step block.
`default_nettype none

package sws_pkg;

    // Field and arithmetic widths.
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 31;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int FRAC_W     = 16;
    localparam int TERM_W     = PROD_W - FRAC_W;
    localparam int SUM_W      = TERM_W + 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 11;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_OVER_DZ = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_OVER_DX = 8'd3;

    // One grid point as it arrives.
    typedef struct packed {
        logic signed [DATA_W-1:0] vel_old;
        logic signed [DATA_W-1:0] szy_old;
        logic signed [DATA_W-1:0] szy_below;
        logic signed [DATA_W-1:0] sxy_old;
        logic signed [DATA_W-1:0] sxy_right;
        logic [COEF_W-1:0]        buoyancy;
        logic [COEF_W-1:0]        shear_modulus;
    } sws_point_t;

    // Position class of a point, decided by the front.
    typedef struct packed {
        logic upd_vel;
        logic upd_stress;
        logic frame_end;
    } sws_flags_t;

    // Time step ratios used by the back.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] step_dz;
        logic [CFG_DATA_W-1:0] step_dx;
    } sws_steps_t;

    // Coefficient from a step times material product: drop 16 bits, clip to 2^31 - 1.
    function automatic logic [COEF_W-1:0] coef_sat(input logic signed [PROD_W-1:0] p);
        logic [COEF_W-1:0] c;
        if (|p[PROD_W-1:FRAC_W+COEF_W])
            c = {COEF_W{1'b1}};
        else
            c = p[FRAC_W+COEF_W-1:FRAC_W];
        return c;
    endfunction

    // Term from a coefficient times difference product, rounded toward minus infinity.
    function automatic logic signed [TERM_W-1:0] term_of(input logic signed [PROD_W-1:0] p);
        return p[PROD_W-1:FRAC_W];
    endfunction

    // Saturate a wide sum to the signed data range.
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))
            r = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sws_chan_if.sv
// Channel interfaces of the SH-wave grid step block: points, results and configuration.
`default_nettype none

interface sws_point_if;
    import sws_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] vel_old;
    logic signed [DATA_W-1:0] szy_old;
    logic signed [DATA_W-1:0] szy_below;
    logic signed [DATA_W-1:0] sxy_old;
    logic signed [DATA_W-1:0] sxy_right;
    logic [COEF_W-1:0]        buoyancy;
    logic [COEF_W-1:0]        shear_modulus;

    modport source (output valid, vel_old, szy_old, szy_below, sxy_old, sxy_right,
                    buoyancy, shear_modulus, input ready);
    modport sink (input valid, vel_old, szy_old, szy_below, sxy_old, sxy_right,
                  buoyancy, shear_modulus, output ready);
endinterface

interface sws_result_if;
    import sws_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] vel_new;
    logic signed [DATA_W-1:0] szy_new;
    logic signed [DATA_W-1:0] sxy_new;
    logic                     frame_end;

    modport source (output valid, vel_new, szy_new, sxy_new, frame_end, input ready);
    modport sink (input valid, vel_new, szy_new, sxy_new, frame_end, output ready);
endinterface

interface sws_cfg_if;
    import sws_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sws_front.sv
// Front of the grid step block: configuration registers, raster position and point classing.
`default_nettype none

module sws_front
    import sws_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    sws_point_if.sink                        point,
    sws_cfg_if.sink                          cfg,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output sws_point_t                       push_point,
    output sws_flags_t                       push_flags,
    output logic [$clog2(MAX_COLS)-1:0]      push_col,
    output sws_steps_t                       steps
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    logic [ROWS_CFG_W-1:0] grid_rows_reg;
    logic [COLS_CFG_W-1:0] grid_cols_reg;
    logic [CFG_DATA_W-1:0] step_dz_reg;
    logic [CFG_DATA_W-1:0] step_dx_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_last;
    logic [COL_W-1:0]      col_last;
    logic                  last_row;
    logic                  last_col;
    logic                  take;
    logic                  cfg_take;
    logic                  size_write;

    // Configuration writes are always taken.
    assign cfg.ready  = 1'b1;
    assign cfg_take   = cfg.valid;
    assign size_write = cfg_take && (cfg.index == REG_GRID_ROWS || cfg.index == REG_GRID_COLS);

    // Last row and column index, with the sizes clamped to their legal range.
    always_comb
    begin
        if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            row_last = ROW_W'(MAX_ROWS - 1);
        else if (grid_rows_reg < ROWS_CFG_W'(2))
            row_last = ROW_W'(1);
        else
            row_last = ROW_W'(grid_rows_reg - ROWS_CFG_W'(1));

        if (32'(grid_cols_reg) > 32'(MAX_COLS))
            col_last = COL_W'(MAX_COLS - 1);
        else if (grid_cols_reg < COLS_CFG_W'(2))
            col_last = COL_W'(1);
        else
            col_last = COL_W'(grid_cols_reg - COLS_CFG_W'(1));
    end

    // Classify the point at the current position.
    assign last_row = row_reg >= row_last;
    assign last_col = col_reg >= col_last;

    assign push_valid            = point.valid;
    assign point.ready           = push_ready;
    assign take                  = point.valid && push_ready;
    assign push_flags.upd_vel    = !last_row && !last_col;
    assign push_flags.upd_stress = (row_reg != '0) && (col_reg != '0);
    assign push_flags.frame_end  = last_row && last_col;
    assign push_col              = col_reg;

    assign push_point.vel_old       = point.vel_old;
    assign push_point.szy_old       = point.szy_old;
    assign push_point.szy_below     = point.szy_below;
    assign push_point.sxy_old       = point.sxy_old;
    assign push_point.sxy_right     = point.sxy_right;
    assign push_point.buoyancy      = point.buoyancy;
    assign push_point.shear_modulus = point.shear_modulus;

    assign steps.step_dz = step_dz_reg;
    assign steps.step_dx = step_dx_reg;

    // Register file and raster position; a size write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ROWS_CFG_W'(2);
            grid_cols_reg <= COLS_CFG_W'(2);
            step_dz_reg   <= '0;
            step_dx_reg   <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            if (cfg_take)
            begin
                unique case (cfg.index)
                    REG_GRID_ROWS:    grid_rows_reg <= cfg.data[ROWS_CFG_W-1:0];
                    REG_GRID_COLS:    grid_cols_reg <= cfg.data[COLS_CFG_W-1:0];
                    REG_STEP_OVER_DZ: step_dz_reg   <= cfg.data;
                    REG_STEP_OVER_DX: step_dx_reg   <= cfg.data;
                    default:          ;
                endcase
            end

            if (size_write)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (take)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sws_queue.sv
// Short first-in first-out queue that parts the front from the back.
`default_nettype none

module sws_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sws_back.sv
// Back of the grid step block: shared multiplier sequencer, line buffer and result register.
`default_nettype none

module sws_back
    import sws_pkg::*;
#(
    parameter int MAX_COLS = 1024
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pop_valid,
    output logic                             pop_ready,
    input  wire sws_point_t                  pop_point,
    input  wire sws_flags_t                  pop_flags,
    input  wire logic [$clog2(MAX_COLS)-1:0] pop_col,
    input  wire sws_steps_t                  steps,
    sws_result_if.source                     result
);

    localparam int COL_W = $clog2(MAX_COLS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF_DZB,
        ST_COEF_DXB,
        ST_COEF_DZS,
        ST_COEF_DXS,
        ST_TERM_Z,
        ST_TERM_X,
        ST_VEL,
        ST_DIFF,
        ST_STRESS_Z,
        ST_STRESS_X,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Working registers of the point in flight.
    sws_point_t                 cur_reg;
    sws_flags_t                 flags_reg;
    logic [COL_W-1:0]           col_reg;
    logic signed [DIFF_W-1:0]   diff_z_reg;
    logic signed [DIFF_W-1:0]   diff_x_reg;
    logic [COEF_W-1:0]          cz_b_reg;
    logic [COEF_W-1:0]          cx_b_reg;
    logic [COEF_W-1:0]          cz_s_reg;
    logic [COEF_W-1:0]          cx_s_reg;
    logic signed [TERM_W-1:0]   term_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [DATA_W-1:0]   vel_new_reg;
    logic signed [DATA_W-1:0]   szy_new_reg;
    logic signed [DATA_W-1:0]   left_reg;
    logic signed [DATA_W-1:0]   up_reg;
    logic signed [DATA_W-1:0]   line_mem [MAX_COLS];

    // Result register.
    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   out_vel_reg;
    logic signed [DATA_W-1:0]   out_szy_reg;
    logic signed [DATA_W-1:0]   out_sxy_reg;
    logic                       out_frame_end_reg;

    logic signed [DIFF_W-1:0]   mul_a;
    logic signed [DIFF_W-1:0]   mul_b;
    logic signed [SUM_W-1:0]    vel_sum;
    logic signed [SUM_W-1:0]    szy_sum;
    logic signed [SUM_W-1:0]    sxy_sum;
    logic signed [DATA_W-1:0]   sxy_final;
    logic                       load_out;

    assign pop_ready        = state_reg == ST_IDLE;
    assign load_out         = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign result.valid     = out_valid_reg;
    assign result.vel_new   = out_vel_reg;
    assign result.szy_new   = out_szy_reg;
    assign result.sxy_new   = out_sxy_reg;
    assign result.frame_end = out_frame_end_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_COEF_DZB:
            begin
                mul_a = $signed({1'b0, steps.step_dz});
                mul_b = $signed({2'b00, cur_reg.buoyancy});
            end
            ST_COEF_DXB:
            begin
                mul_a = $signed({1'b0, steps.step_dx});
                mul_b = $signed({2'b00, cur_reg.buoyancy});
            end
            ST_COEF_DZS:
            begin
                mul_a = $signed({1'b0, steps.step_dz});
                mul_b = $signed({2'b00, cur_reg.shear_modulus});
            end
            ST_COEF_DXS:
            begin
                mul_a = $signed({1'b0, steps.step_dx});
                mul_b = $signed({2'b00, cur_reg.shear_modulus});
            end
            ST_TERM_Z:
            begin
                mul_a = $signed({2'b00, cz_b_reg});
                mul_b = diff_z_reg;
            end
            ST_TERM_X:
            begin
                mul_a = $signed({2'b00, cx_b_reg});
                mul_b = diff_x_reg;
            end
            ST_STRESS_Z:
            begin
                mul_a = $signed({2'b00, cz_s_reg});
                mul_b = diff_z_reg;
            end
            ST_STRESS_X:
            begin
                mul_a = $signed({2'b00, cx_s_reg});
                mul_b = diff_x_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Sums that close the velocity and stress updates.
    assign vel_sum   = SUM_W'(cur_reg.vel_old) + SUM_W'(term_reg) + SUM_W'(term_of(prod_reg));
    assign szy_sum   = SUM_W'(cur_reg.szy_old) + SUM_W'(term_of(prod_reg));
    assign sxy_sum   = SUM_W'(cur_reg.sxy_old) + SUM_W'(term_of(prod_reg));
    assign sxy_final = flags_reg.upd_stress ? sat_data(sxy_sum) : cur_reg.sxy_old;

    // Sequencer steps.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (pop_valid) state_next = ST_COEF_DZB;
            ST_COEF_DZB: state_next = ST_COEF_DXB;
            ST_COEF_DXB: state_next = ST_COEF_DZS;
            ST_COEF_DZS: state_next = ST_COEF_DXS;
            ST_COEF_DXS: state_next = ST_TERM_Z;
            ST_TERM_Z:   state_next = ST_TERM_X;
            ST_TERM_X:   state_next = ST_VEL;
            ST_VEL:      state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_STRESS_Z;
            ST_STRESS_Z: state_next = ST_STRESS_X;
            ST_STRESS_X: state_next = ST_DONE;
            ST_DONE:     if (load_out) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            out_vel_reg       <= '0;
            out_szy_reg       <= '0;
            out_sxy_reg       <= '0;
            out_frame_end_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg     <= 1'b1;
                out_vel_reg       <= vel_new_reg;
                out_szy_reg       <= szy_new_reg;
                out_sxy_reg       <= sxy_final;
                out_frame_end_reg <= flags_reg.frame_end;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, loaded step by step.
    always_ff @(posedge clk)
    begin
        // The last stress product is held while the finished point waits.
        if (state_reg != ST_DONE)
            prod_reg <= prod_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_reg    <= pop_point;
                    flags_reg  <= pop_flags;
                    col_reg    <= pop_col;
                    diff_z_reg <= DIFF_W'(pop_point.szy_below) - DIFF_W'(pop_point.szy_old);
                    diff_x_reg <= DIFF_W'(pop_point.sxy_right) - DIFF_W'(pop_point.sxy_old);
                end
            end
            ST_COEF_DXB: cz_b_reg <= coef_sat(prod_reg);
            ST_COEF_DZS: cx_b_reg <= coef_sat(prod_reg);
            ST_COEF_DXS: cz_s_reg <= coef_sat(prod_reg);
            ST_TERM_Z:   cx_s_reg <= coef_sat(prod_reg);
            ST_TERM_X:   term_reg <= term_of(prod_reg);
            ST_VEL:      vel_new_reg <= flags_reg.upd_vel ? sat_data(vel_sum) : cur_reg.vel_old;
            ST_DIFF:
            begin
                diff_z_reg <= DIFF_W'(vel_new_reg) - DIFF_W'(up_reg);
                diff_x_reg <= DIFF_W'(vel_new_reg) - DIFF_W'(left_reg);
                left_reg   <= vel_new_reg;
            end
            ST_STRESS_X: szy_new_reg <= flags_reg.upd_stress ? sat_data(szy_sum) : cur_reg.szy_old;
            default:     ;
        endcase
    end

    // Line buffer of the previous row's new velocities; read before the write of this point.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIFF)
            line_mem[col_reg] <= vel_new_reg;
        up_reg <= line_mem[col_reg];
    end

`ifndef ASSERT_OFF
    ap_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && pop_valid) |=> (state_reg == ST_COEF_DZB))
        else $error("Back did not start on a queued point.");

    ap_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !result.ready)
            |=> (state_reg == ST_DONE && out_valid_reg))
        else $error("Pending result was overwritten or dropped.");

    ap_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("Result register loaded outside the final step.");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sh_wave_staggered_grid_step_top.sv
// Top level of the SH-wave staggered-grid step block: front, queue and back.
//
//   channel   direction   transaction
//   point     in          one grid point in raster order with its old fields
//   result    out         new velocity and stresses of one point, frame_end mark
//   cfg       in          register write: index and data
//
// The back works on one point at a time: one shared multiplier forms four
// coefficients and four terms in sequence, with the add and saturate steps between.
// The front takes points into a 4-entry queue while the back works.
// The result register holds a finished point while the back takes the next one.
// After reset the block takes points at once; no clearing pass is needed because
// every line buffer entry is written in row 0 before any later row reads it.
`default_nettype none

module sh_wave_staggered_grid_step_top
    import sws_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    sws_point_if.sink    point,
    sws_result_if.source result,
    sws_cfg_if.sink      cfg
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int Q_W   = COL_W + $bits(sws_flags_t) + $bits(sws_point_t);

    logic             push_valid;
    logic             push_ready;
    sws_point_t       push_point;
    sws_flags_t       push_flags;
    logic [COL_W-1:0] push_col;
    logic             pop_valid;
    logic             pop_ready;
    sws_point_t       pop_point;
    sws_flags_t       pop_flags;
    logic [COL_W-1:0] pop_col;
    logic [Q_W-1:0]   push_data;
    logic [Q_W-1:0]   pop_data;
    sws_steps_t       steps;

    sws_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_point (push_point),
        .push_flags (push_flags),
        .push_col   (push_col),
        .steps      (steps)
    );

    // Classified points are packed into one queue entry.
    assign push_data = {push_col, push_flags, push_point};
    assign {pop_col, pop_flags, pop_point} = pop_data;

    sws_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sws_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_point (pop_point),
        .pop_flags (pop_flags),
        .pop_col   (pop_col),
        .steps     (steps),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> tb/sws_grid_step_checker.sv
// Scoreboard for the SH-wave grid step block: predicts every result and compares it.
`timescale 1ns / 100ps

module sws_grid_step_checker
    import sws_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
)
(
    input  logic  clk,
    input  logic  rst_n,
    sws_point_if  point,
    sws_result_if result,
    sws_cfg_if    cfg,
    output int    failures,
    output int    outstanding
);

    localparam longint COEF_CAP    = 64'sh7FFF_FFFF;
    localparam longint DATA_MAX    = 64'sh7FFF_FFFF;
    localparam longint DATA_MIN    = -64'sd2147483648;
    localparam int     PRINT_LIMIT = 40;

    // Expected content of one result transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] vel_new;
        logic signed [DATA_W-1:0] szy_new;
        logic signed [DATA_W-1:0] sxy_new;
        logic                     frame_end;
    } grid_result_t;

    // Shadow copy of the registers and of the grid state.
    logic [ROWS_CFG_W-1:0]    grid_rows;
    logic [COLS_CFG_W-1:0]    grid_cols;
    logic [CFG_DATA_W-1:0]    step_dz;
    logic [CFG_DATA_W-1:0]    step_dx;
    logic signed [DATA_W-1:0] line_vel [MAX_COLS];
    logic signed [DATA_W-1:0] left_vel;
    int                       row_pos;
    int                       col_pos;
    grid_result_t             expected_results [$];

    function automatic int clamp_size(input int v, input int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Material coefficient: step times material, 16 fraction bits dropped, capped.
    function automatic longint coef_from(input logic [CFG_DATA_W-1:0] step,
                                         input logic [COEF_W-1:0] material);
        longint unsigned prod;
        prod = ({32'b0, step} * {33'b0, material}) >> FRAC_W;
        if (prod > COEF_CAP)
            prod = COEF_CAP;
        return longint'(prod);
    endfunction

    // Coefficient times difference, floored back to Q16.16.
    function automatic longint scaled_term(input longint coef, input longint diff);
        longint prod;
        prod = coef * diff;
        return prod >>> FRAC_W;
    endfunction

    function automatic logic signed [DATA_W-1:0] clip_data(input longint v);
        if (v > DATA_MAX)
            return 32'sh7FFF_FFFF;
        if (v < DATA_MIN)
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    // Predict one grid point and advance the raster position.
    function automatic grid_result_t step_grid_point(input sws_point_t pt);
        int           rows_used;
        int           cols_used;
        bit           last_row;
        bit           last_col;
        longint       szy;
        longint       sxy;
        longint       v_new;
        grid_result_t r;
        rows_used = clamp_size(int'(grid_rows), MAX_ROWS);
        cols_used = clamp_size(int'(grid_cols), MAX_COLS);
        last_row  = row_pos >= rows_used - 1;
        last_col  = col_pos >= cols_used - 1;
        szy       = longint'($signed(pt.szy_old));
        sxy       = longint'($signed(pt.sxy_old));
        v_new     = longint'($signed(pt.vel_old));

        // Velocity is only updated away from the last row and the last column.
        if (!last_row && !last_col)
            v_new = clip_data(v_new
                + scaled_term(coef_from(step_dz, pt.buoyancy),
                              longint'($signed(pt.szy_below)) - szy)
                + scaled_term(coef_from(step_dx, pt.buoyancy),
                              longint'($signed(pt.sxy_right)) - sxy));

        r.vel_new = v_new[DATA_W-1:0];
        r.szy_new = pt.szy_old;
        r.sxy_new = pt.sxy_old;

        // Stresses need an upper and a left neighbour.
        if (row_pos >= 1 && col_pos >= 1)
        begin
            r.szy_new = clip_data(szy + scaled_term(coef_from(step_dz, pt.shear_modulus),
                                                    v_new - longint'(line_vel[col_pos])));
            r.sxy_new = clip_data(sxy + scaled_term(coef_from(step_dx, pt.shear_modulus),
                                                    v_new - longint'(left_vel)));
        end

        line_vel[col_pos] = r.vel_new;
        left_vel          = r.vel_new;
        r.frame_end       = last_row && last_col;

        // Raster order with wrap after the last point of the frame.
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return r;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_GRID_ROWS:
            begin
                grid_rows = value[ROWS_CFG_W-1:0];
                row_pos   = 0;
                col_pos   = 0;
            end
            REG_GRID_COLS:
            begin
                grid_cols = value[COLS_CFG_W-1:0];
                row_pos   = 0;
                col_pos   = 0;
            end
            REG_STEP_OVER_DZ: step_dz = value;
            REG_STEP_OVER_DX: step_dx = value;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        failures++;
        if (failures <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Watch all three channels; writes and points are handled before results.
    always @(posedge clk or negedge rst_n)
    begin : watch
        sws_point_t   pt;
        grid_result_t want;
        if (!rst_n)
        begin
            grid_rows = ROWS_CFG_W'(2);
            grid_cols = COLS_CFG_W'(2);
            step_dz   = '0;
            step_dx   = '0;
            for (int i = 0; i < MAX_COLS; i++)
                line_vel[i] = '0;
            left_vel  = '0;
            row_pos   = 0;
            col_pos   = 0;
            failures  = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);

            if (point.valid && point.ready)
            begin
                pt.vel_old       = point.vel_old;
                pt.szy_old       = point.szy_old;
                pt.szy_below     = point.szy_below;
                pt.sxy_old       = point.sxy_old;
                pt.sxy_right     = point.sxy_right;
                pt.buoyancy      = point.buoyancy;
                pt.shear_modulus = point.shear_modulus;
                expected_results.push_back(step_grid_point(pt));
            end

            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result transaction with nothing expected, vel_new %h",
                                              result.vel_new));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("vel_new", result.vel_new, want.vel_new);
                    check_field("szy_new", result.szy_new, want.szy_new);
                    check_field("sxy_new", result.sxy_new, want.sxy_new);
                    check_field("frame_end", {31'b0, result.frame_end}, {31'b0, want.frame_end});
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

>>> tb/sh_wave_staggered_grid_step_top_tb.sv
// Testbench top for the SH-wave grid step block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sh_wave_staggered_grid_step_top_tb;
    import sws_pkg::*;

    localparam int TIMEOUT_NS   = 1_500_000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int WIDE_ITEMS   = 1040;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    typedef enum int {
        FILL_DIRECTED,
        FILL_FULL,
        FILL_SMALL,
        FILL_EXTREME,
        FILL_MIXED
    } fill_kind_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   random_sent;
    bit   hold_req;
    bit   source_quiet;
    bit   sink_quiet;

    sws_point_if  point_ch();
    sws_result_if result_ch();
    sws_cfg_if    cfg_ch();

    sh_wave_staggered_grid_step_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    sws_grid_step_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .point       (point_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .failures    (fail_count),
        .outstanding (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Field values at the edges of the signed range.
    function automatic logic signed [DATA_W-1:0] extreme_word(input int i);
        case (i % 5)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return 32'sh0001_0000;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] coef_word(input int i);
        case (i % 3)
            0:       return 31'h7FFF_FFFF;
            1:       return 31'h0;
            default: return 31'h0001_0000;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] small_word();
        return DATA_W'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    // Mostly modest time steps, with zero, full scale and raw random mixed in.
    function automatic logic [CFG_DATA_W-1:0] step_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll < 4)
            return $urandom;
        return $urandom_range(0, 32'h0002_0000);
    endfunction

    // Idle lengths: mostly short, now and then long.
    function automatic int gap_cycles();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic sws_point_t make_point(input fill_kind_t kind, input int k);
        sws_point_t p;
        fill_kind_t pick;
        pick = kind;
        if (kind == FILL_MIXED)
            pick = fill_kind_t'($urandom_range(FILL_FULL, FILL_EXTREME));
        case (pick)
            FILL_DIRECTED:
            begin
                p.vel_old       = extreme_word(k);
                p.szy_old       = extreme_word(k + 1);
                p.sxy_old       = extreme_word(k + 2);
                p.szy_below     = extreme_word(k + 3);
                p.sxy_right     = extreme_word(k + 4);
                p.buoyancy      = coef_word(k);
                p.shear_modulus = coef_word(k + 1);
            end
            FILL_SMALL:
            begin
                p.vel_old       = small_word();
                p.szy_old       = small_word();
                p.szy_below     = small_word();
                p.sxy_old       = small_word();
                p.sxy_right     = small_word();
                p.buoyancy      = COEF_W'($urandom_range(0, 32'h0002_0000));
                p.shear_modulus = COEF_W'($urandom_range(0, 32'h0002_0000));
            end
            FILL_EXTREME:
            begin
                p.vel_old       = extreme_word($urandom_range(0, 4));
                p.szy_old       = extreme_word($urandom_range(0, 4));
                p.szy_below     = extreme_word($urandom_range(0, 4));
                p.sxy_old       = extreme_word($urandom_range(0, 4));
                p.sxy_right     = extreme_word($urandom_range(0, 4));
                p.buoyancy      = coef_word($urandom_range(0, 2));
                p.shear_modulus = coef_word($urandom_range(0, 2));
            end
            default:
            begin
                p.vel_old       = $urandom;
                p.szy_old       = $urandom;
                p.szy_below     = $urandom;
                p.sxy_old       = $urandom;
                p.sxy_right     = $urandom;
                p.buoyancy      = COEF_W'($urandom);
                p.shear_modulus = COEF_W'($urandom);
            end
        endcase
        return p;
    endfunction

    // Starts at a rising edge; leaves valid high so writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic set_grid(input logic [ROWS_CFG_W-1:0] rows,
                            input logic [COLS_CFG_W-1:0] cols);
        write_reg(REG_GRID_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_GRID_COLS, CFG_DATA_W'(cols));
    endtask

    task automatic set_steps(input logic [CFG_DATA_W-1:0] dz, input logic [CFG_DATA_W-1:0] dx);
        write_reg(REG_STEP_OVER_DZ, dz);
        write_reg(REG_STEP_OVER_DX, dx);
    endtask

    // Block until every predicted result has been seen.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic drive_point(input sws_point_t p);
        point_ch.valid         <= 1'b1;
        point_ch.vel_old       <= p.vel_old;
        point_ch.szy_old       <= p.szy_old;
        point_ch.szy_below     <= p.szy_below;
        point_ch.sxy_old       <= p.sxy_old;
        point_ch.sxy_right     <= p.sxy_right;
        point_ch.buoyancy      <= p.buoyancy;
        point_ch.shear_modulus <= p.shear_modulus;
        do
            @(posedge clk);
        while (!point_ch.ready);
    endtask

    task automatic send_points(input int count, input fill_kind_t kind, input int first);
        for (int i = 0; i < count; i++)
        begin
            if (!source_quiet && $urandom_range(0, 2) == 0)
            begin
                point_ch.valid <= 1'b0;
                repeat (gap_cycles()) @(posedge clk);
            end
            drive_point(make_point(kind, first + i));
        end
        point_ch.valid <= 1'b0;
        if (kind != FILL_DIRECTED)
            random_sent += count;
    endtask

    // Result side: random stalls, plus one long hold when requested.
    initial
    begin : result_sink
        bit held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (!sink_quiet && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap_cycles()) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int         rows_pick;
        int         cols_pick;
        int         count;
        int         roll;
        fill_kind_t kind;

        point_ch.valid         <= 1'b0;
        point_ch.vel_old       <= '0;
        point_ch.szy_old       <= '0;
        point_ch.szy_below     <= '0;
        point_ch.sxy_old       <= '0;
        point_ch.sxy_right     <= '0;
        point_ch.buoyancy      <= '0;
        point_ch.shear_modulus <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= '0;
        cfg_ch.data            <= '0;
        rst_n                  <= 1'b0;
        hold_req     = 1'b0;
        source_quiet = 1'b0;
        sink_quiet   = 1'b0;
        random_sent  = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 3x3 frame with full-scale steps so the coefficients clip,
        // then a second frame with modest steps that wraps and continues.
        set_grid(3, 3);
        set_steps('1, '1);
        cfg_ch.valid <= 1'b0;
        send_points(9, FILL_DIRECTED, 0);
        wait_idle();
        set_steps(32'h0000_4000, 32'h0001_8000);
        cfg_ch.valid <= 1'b0;
        send_points(9, FILL_DIRECTED, 9);

        // Writes to undecoded indexes must leave the frame position alone.
        wait_idle();
        write_reg(REG_SPARE, 32'd1);
        write_reg(REG_TOP_INDEX, 32'd5);
        cfg_ch.valid <= 1'b0;
        send_points(4, FILL_DIRECTED, 18);

        // Grid sizes below and above the legal range get clamped.
        wait_idle();
        set_grid(0, 1);
        set_steps(32'h0001_0000, 32'h0000_8000);
        cfg_ch.valid <= 1'b0;
        send_points(8, FILL_MIXED, 0);
        wait_idle();
        set_grid('1, '1);
        set_steps(32'h0000_2000, 32'h0000_3000);
        cfg_ch.valid <= 1'b0;
        send_points(20, FILL_MIXED, 0);

        // Widest grid: past the last column into row 1, with a long result hold
        // while the source keeps offering points.
        wait_idle();
        set_grid(2, 1024);
        set_steps(32'h0000_8000, 32'h0000_C000);
        cfg_ch.valid <= 1'b0;
        source_quiet = 1'b1;
        hold_req     = 1'b1;
        send_points(WIDE_ITEMS, FILL_MIXED, 0);
        source_quiet = 1'b0;

        // Random phases: mostly small grids run through whole frames.
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            roll = $urandom_range(0, 9);
            if (roll < 6)
            begin
                rows_pick = $urandom_range(2, 5);
                cols_pick = $urandom_range(2, 6);
                set_grid(ROWS_CFG_W'(rows_pick), COLS_CFG_W'(cols_pick));
                count = rows_pick * cols_pick * $urandom_range(1, 2) + $urandom_range(0, 3);
            end
            else if (roll < 8)
            begin
                set_grid(ROWS_CFG_W'($urandom), COLS_CFG_W'($urandom));
                count = $urandom_range(8, 40);
            end
            else
                count = $urandom_range(4, 30);
            set_steps(step_value(), step_value());
            cfg_ch.valid <= 1'b0;
            source_quiet = ($urandom_range(0, 3) == 0);
            sink_quiet   = ($urandom_range(0, 3) == 0);
            kind = fill_kind_t'($urandom_range(FILL_FULL, FILL_MIXED));
            send_points(count, kind, 0);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
